/* design/dfs_pkg.sv */
// ----------------------------------------------------------------------------
// Delimited field selector package
// Shared types, byte codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package dfs_pkg;

    typedef logic [7:0] t_byte;

    localparam t_byte NEWLINE_BYTE  = 8'd10;
    localparam t_byte DEFAULT_DELIM = 8'd9;
    localparam t_byte FIELD_MAX     = 8'd255;

    // register indexes, taken from paddr[4:3]
    localparam logic [1:0] REG_DELIM = 2'd0;
    localparam logic [1:0] REG_MASK  = 2'd1;
    localparam logic [1:0] REG_OPEN  = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_DSEL = 6'b000100,
        S_RD   = 6'b001000,
        S_EMIT = 6'b010000,
        S_NL   = 6'b100000
    } t_state;

endpackage

`default_nettype wire

/* design/dfs_if.sv */
// ----------------------------------------------------------------------------
// Delimited field selector stream interfaces
// Valid/ready channels for input bytes and output bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfs_in_if;
    import dfs_pkg::*;

    logic  valid;
    logic  ready;
    t_byte in_byte;
    logic  end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface dfs_out_if;
    import dfs_pkg::*;

    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

/* design/delimited_field_selector_unit.sv */
// Sequence: a request is taken in S_IDLE and evaluated in S_EVAL in the next cycle; a byte
//   that passes straight through goes from r_byte into the output register.
// Flow: one input byte is in work at a time, accepted, then evaluated; a delimiter adds
//   S_DSEL and a line end S_NL; a full output register stalls the sequencer. Replay of a
//   held first field steps S_RD, S_EMIT per byte (one held-buffer read port), then S_NL.
// Reset: synchronous, active low; the held buffer is not cleared, r_held covers it.
// ----------------------------------------------------------------------------
// Delimited field selector unit
// Streams text bytes and passes on the selected delimiter-separated fields.
// ----------------------------------------------------------------------------
`default_nettype none

module delimited_field_selector_unit #(
    parameter int MASK_FIELDS = 64,
    parameter int HOLD_DEPTH  = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    dfs_in_if.sink       i_in,
    dfs_out_if.source    o_out,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [4:0]   paddr,
    input  wire  [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import dfs_pkg::*;

    localparam int MI_W  = (MASK_FIELDS > 1) ? $clog2(MASK_FIELDS) : 1;
    localparam int IDX_W = $clog2(HOLD_DEPTH);
    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);

    // configuration
    t_byte                  r_delim;
    logic [MASK_FIELDS-1:0] r_mask;
    t_byte                  r_open;

    // sequencer and line state
    t_state            r_state,     n_state;
    t_byte             r_byte,      n_byte;
    logic              r_eoi,       n_eoi;
    t_byte             r_field,     n_field;
    logic              r_saw,       n_saw;
    logic              r_emitted,   n_emitted;
    logic              r_nonempty,  n_nonempty;
    logic [CNT_W-1:0]  r_held,      n_held;
    logic [IDX_W-1:0]  r_idx,       n_idx;

    // output register
    logic              r_ov,        n_ov;
    t_byte             r_obyte,     n_obyte;
    logic              r_olast,     n_olast;

    // held first-field buffer
    t_byte             mem_held [HOLD_DEPTH];
    t_byte             r_rd_data;
    logic              w_we;

    logic              w_sel;
    logic              w_out_free;
    logic              w_cfg_wr;
    t_byte             w_field_m1;

    // shared selection compare, always on the current field number
    assign w_field_m1 = r_field - 8'd1;
    assign w_sel = ((r_field != 8'd0) && ({24'd0, r_field} <= 32'(MASK_FIELDS))
                    && r_mask[w_field_m1[MI_W-1:0]])
                   || ((r_open != 8'd0) && (r_field >= r_open));

    assign w_out_free = !r_ov || o_out.ready;

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_obyte;
    assign o_out.last     = r_olast;

    always_comb begin
        n_state    = r_state;
        n_byte     = r_byte;
        n_eoi      = r_eoi;
        n_field    = r_field;
        n_saw      = r_saw;
        n_emitted  = r_emitted;
        n_nonempty = r_nonempty;
        n_held     = r_held;
        n_idx      = r_idx;
        n_ov       = r_ov;
        n_obyte    = r_obyte;
        n_olast    = r_olast;
        w_we       = 1'b0;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_byte  = i_in.in_byte;
                    n_eoi   = i_in.end_of_input;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                priority if (r_eoi && !r_nonempty) begin
                    n_field    = 8'd1;
                    n_saw      = 1'b0;
                    n_emitted  = 1'b0;
                    n_held     = '0;
                    n_state    = S_IDLE;
                end else if (r_eoi || (r_byte == NEWLINE_BYTE)) begin
                    // finish line: replay held first field if nothing split it
                    if (!r_saw && !w_sel && (r_held != '0)) begin
                        n_idx   = '0;
                        n_state = S_RD;
                    end else begin
                        n_state = S_NL;
                    end
                end else if (r_byte == r_delim) begin
                    n_nonempty = 1'b1;
                    if ((r_field == 8'd1) && w_sel) begin
                        n_emitted = 1'b1;
                    end
                    n_saw  = 1'b1;
                    n_held = '0;
                    if (r_field != FIELD_MAX) begin
                        n_field = r_field + 8'd1;
                    end
                    n_state = S_DSEL;
                end else begin
                    n_nonempty = 1'b1;
                    if (w_sel) begin
                        // hold until the output register frees up
                        if (w_out_free) begin
                            n_ov    = 1'b1;
                            n_obyte = r_byte;
                            n_olast = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else begin
                        if ((r_field == 8'd1) && (r_held < CNT_W'(HOLD_DEPTH))) begin
                            w_we   = 1'b1;
                            n_held = r_held + CNT_W'(1);
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            S_DSEL: begin
                if (w_sel && r_emitted) begin
                    if (w_out_free) begin
                        n_ov    = 1'b1;
                        n_obyte = r_delim;
                        n_olast = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    if (w_sel) begin
                        n_emitted = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_obyte = r_rd_data;
                    n_olast = 1'b0;
                    if ((CNT_W'(r_idx) + CNT_W'(1)) == r_held) begin
                        n_state = S_NL;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_NL: begin
                if (w_out_free) begin
                    n_ov       = 1'b1;
                    n_obyte    = NEWLINE_BYTE;
                    n_olast    = 1'b1;
                    n_field    = 8'd1;
                    n_saw      = 1'b0;
                    n_emitted  = 1'b0;
                    n_nonempty = 1'b0;
                    n_held     = '0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_field    <= 8'd1;
            r_saw      <= 1'b0;
            r_emitted  <= 1'b0;
            r_nonempty <= 1'b0;
            r_held     <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_field    <= n_field;
            r_saw      <= n_saw;
            r_emitted  <= n_emitted;
            r_nonempty <= n_nonempty;
            r_held     <= n_held;
            r_ov       <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_eoi   <= n_eoi;
        r_idx   <= n_idx;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
    end

    // held buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_held[r_held[IDX_W-1:0]] <= r_byte;
        end
        r_rd_data <= mem_held[r_idx];
    end

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DEFAULT_DELIM;
            r_mask  <= '0;
            r_open  <= 8'd0;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:3])
                REG_DELIM: r_delim <= pwdata[7:0];
                REG_MASK:  r_mask  <= pwdata[MASK_FIELDS-1:0];
                REG_OPEN:  r_open  <= pwdata[7:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_DELIM: prdata = {56'd0, r_delim};
            REG_MASK:  prdata = 64'(r_mask);
            REG_OPEN:  prdata = {56'd0, r_open};
            default:   prdata = 64'd0;
        endcase
    end

    // checks
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_W'(HOLD_DEPTH))
        else $error("held count beyond buffer depth");

    a_saw_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_saw |-> (r_held == '0))
        else $error("held bytes kept after a delimiter");

    a_first_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_saw |-> (r_field == 8'd1))
        else $error("field number advanced without a delimiter");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request taken while previous byte in evaluation");

endmodule

`default_nettype wire

/* tb/sv/dfs_cut_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Field selector output checker
// Watches the byte channels and the register port, predicts the selected
// output bytes of every accepted request and compares them in order.
// ----------------------------------------------------------------------------

module dfs_cut_checker #(
    parameter int MASK_FIELDS = 64,
    parameter int HOLD_DEPTH  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dfs_in_if           in_mon,
    dfs_out_if          out_mon,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output int          o_fail_count,
    output int          o_pending
);
    import dfs_pkg::*;

    typedef struct packed {
        t_byte data;
        logic  last;
    } t_cut_byte;

    t_cut_byte   cut_bytes_q[$];
    t_byte       line_bytes[$];
    t_cut_byte   head;

    t_byte       sep_byte;
    logic [63:0] sel_mask;
    t_byte       open_start;

    t_byte       fld_no;
    logic        seen_sep;
    logic        wrote_field;
    logic        has_text;
    t_byte       hold_mem [HOLD_DEPTH];
    int          hold_cnt;
    int          fail_cnt;

    function automatic logic field_on(int k);
        if (k >= 1 && k <= MASK_FIELDS && sel_mask[k-1]) begin
            return 1'b1;
        end
        return open_start != 8'd0 && k >= int'(open_start);
    endfunction

    function automatic void clear_line();
        fld_no      = 8'd1;
        seen_sep    = 1'b0;
        wrote_field = 1'b0;
        has_text    = 1'b0;
        hold_cnt    = 0;
    endfunction

    // replay an unselected first field only when the line never split
    function automatic void end_line();
        if (!seen_sep && !field_on(1)) begin
            for (int i = 0; i < hold_cnt; i++) begin
                line_bytes.insert(line_bytes.size(), hold_mem[i]);
            end
        end
        line_bytes.insert(line_bytes.size(), NEWLINE_BYTE);
        clear_line();
    endfunction

    function automatic void cut_step(t_byte b, logic eoi);
        t_cut_byte item;
        line_bytes.delete();
        if (eoi) begin
            if (has_text) begin
                end_line();
            end else begin
                clear_line();
            end
        end else if (b == NEWLINE_BYTE) begin
            end_line();
        end else if (b == sep_byte) begin
            has_text = 1'b1;
            if (fld_no == 8'd1 && field_on(1)) begin
                wrote_field = 1'b1;
            end
            seen_sep = 1'b1;
            hold_cnt = 0;
            if (fld_no != FIELD_MAX) begin
                fld_no = fld_no + 8'd1;
            end
            if (field_on(int'(fld_no))) begin
                if (wrote_field) begin
                    line_bytes.insert(line_bytes.size(), sep_byte);
                end
                wrote_field = 1'b1;
            end
        end else begin
            has_text = 1'b1;
            if (field_on(int'(fld_no))) begin
                line_bytes.insert(line_bytes.size(), b);
            end else if (fld_no == 8'd1 && hold_cnt < HOLD_DEPTH) begin
                hold_mem[hold_cnt] = b;
                hold_cnt++;
            end
        end
        for (int i = 0; i < line_bytes.size(); i++) begin
            item.data = line_bytes[i];
            item.last = (i == line_bytes.size() - 1);
            cut_bytes_q.insert(cut_bytes_q.size(), item);
        end
    endfunction

    function automatic void note_fail(string msg);
        fail_cnt++;
        if (fail_cnt <= 10) begin
            $display("%0t: output mismatch: %s", $time, msg);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sep_byte   = DEFAULT_DELIM;
            sel_mask   = '0;
            open_start = '0;
            clear_line();
            cut_bytes_q.delete();
            fail_cnt   = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:3])
                    REG_DELIM: sep_byte   = pwdata[7:0];
                    REG_MASK:  sel_mask   = pwdata;
                    REG_OPEN:  open_start = pwdata[7:0];
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready) begin
                cut_step(in_mon.in_byte, in_mon.end_of_input);
            end
            if (out_mon.valid && out_mon.ready) begin
                if (cut_bytes_q.size() == 0) begin
                    note_fail($sformatf("expected nothing, got byte %02h last %0b",
                                        out_mon.out_byte, out_mon.last));
                end else begin
                    head = cut_bytes_q.pop_front();
                    if (head.data !== out_mon.out_byte || head.last !== out_mon.last) begin
                        note_fail($sformatf("expected byte %02h last %0b, got byte %02h last %0b",
                                            head.data, head.last,
                                            out_mon.out_byte, out_mon.last));
                    end
                end
            end
        end
        o_pending    <= cut_bytes_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited field selector testbench
// Drives text lines under several delimiter and field selections, with
// random idling on both byte channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------

module tb_top;
    import dfs_pkg::*;

    localparam int MASK_FIELDS   = 64;
    localparam int HOLD_DEPTH    = 32;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES   = 20;
    localparam t_byte TAB_BYTE   = 8'h09;
    localparam t_byte COMMA_BYTE = 8'h2C;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    int    src_idle_pct   = 0;
    int    sink_stall_pct = 0;
    int    idle_cycles    = 0;
    int    bytes_sent     = 0;
    int    fail_count;
    int    pending;
    t_byte cur_delim      = DEFAULT_DELIM;

    dfs_in_if  in_ch ();
    dfs_out_if out_ch ();

    delimited_field_selector_unit #(
        .MASK_FIELDS (MASK_FIELDS),
        .HOLD_DEPTH  (HOLD_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dfs_cut_checker #(
        .MASK_FIELDS (MASK_FIELDS),
        .HOLD_DEPTH  (HOLD_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_req(input t_byte b, input logic eoi);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.in_byte      <= b;
        in_ch.end_of_input <= eoi;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        bytes_sent++;
    endtask

    // hold off the sender until every predicted byte is out
    task automatic drain_out();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_cut(input t_byte delim, input logic [63:0] mask, input t_byte open);
        reg_write(REG_DELIM, {56'd0, delim});
        reg_write(REG_MASK, mask);
        reg_write(REG_OPEN, {56'd0, open});
        cur_delim = delim;
    endtask

    function automatic t_byte text_byte();
        t_byte c;
        do begin
            c = t_byte'($urandom_range(255));
        end while (c == NEWLINE_BYTE || c == cur_delim);
        return c;
    endfunction

    task automatic send_line(input int max_fields, input int long_pct);
        int nfld;
        int len;
        int pick;
        nfld = $urandom_range(1, max_fields);
        for (int f = 0; f < nfld; f++) begin
            if (f > 0) begin
                send_req(cur_delim, 1'b0);
            end
            // a long first field comes near to or overflows the hold buffer
            if (f == 0 && $urandom_range(99) < long_pct) begin
                len = $urandom_range(HOLD_DEPTH - 2, HOLD_DEPTH + 8);
            end else begin
                len = $urandom_range(0, 4);
            end
            repeat (len) send_req(text_byte(), 1'b0);
        end
        pick = $urandom_range(99);
        if (pick < 75) begin
            send_req(NEWLINE_BYTE, 1'b0);
        end else if (pick < 85) begin
            send_req(t_byte'($urandom_range(255)), 1'b1);
        end else if (pick < 90) begin
            send_req(NEWLINE_BYTE, 1'b0);
            send_req(t_byte'($urandom_range(255)), 1'b1);
        end else if (pick < 95) begin
            send_req(t_byte'($urandom_range(255)), 1'b0);
        end
    endtask

    initial begin
        int phase_start;
        int long_pct;

        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.in_byte      <= '0;
        in_ch.end_of_input <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset selection: nothing selected, so a split line is just a newline
        send_req(8'h00, 1'b0);
        send_req(TAB_BYTE, 1'b0);
        send_req(8'hFF, 1'b0);
        send_req(NEWLINE_BYTE, 1'b0);
        // no delimiter: the held first field comes back
        send_req(8'hFF, 1'b0);
        send_req(8'h41, 1'b0);
        send_req(NEWLINE_BYTE, 1'b0);
        // end of input on an empty line adds no blank line
        send_req(8'hA5, 1'b1);
        drain_out();

        // fields one, three and four; field four is empty
        set_cut(COMMA_BYTE, 64'hD, 8'd0);
        send_req(8'h61, 1'b0);
        send_req(COMMA_BYTE, 1'b0);
        send_req(8'h62, 1'b0);
        send_req(COMMA_BYTE, 1'b0);
        send_req(8'h63, 1'b0);
        send_req(COMMA_BYTE, 1'b0);
        send_req(COMMA_BYTE, 1'b0);
        send_req(8'h64, 1'b0);
        send_req(NEWLINE_BYTE, 1'b0);
        send_req(8'h71, 1'b0);
        send_req(8'h00, 1'b1);
        drain_out();

        // open range from three, plus field sixty-four
        set_cut(COMMA_BYTE, 64'h8000_0000_0000_0000, 8'd3);
        send_req(COMMA_BYTE, 1'b0);
        send_req(COMMA_BYTE, 1'b0);
        send_req(8'h78, 1'b0);
        send_req(COMMA_BYTE, 1'b0);
        send_req(8'h79, 1'b0);
        send_req(NEWLINE_BYTE, 1'b0);
        drain_out();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 46; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 46; end
                default: begin src_idle_pct = 20; sink_stall_pct = 20; end
            endcase
            long_pct = 15;
            case (ph)
                0: set_cut(t_byte'($urandom_range(255)), {$urandom, $urandom}, 8'd0);
                1: set_cut(8'h00, '1, 8'd0);
                2: set_cut(8'hFF, '0, FIELD_MAX);
                3: set_cut(NEWLINE_BYTE, {$urandom, $urandom}, t_byte'($urandom_range(3)));
                4: set_cut(COMMA_BYTE, {32'd0, $urandom}, t_byte'($urandom_range(2, 8)));
                5: begin
                    set_cut(DEFAULT_DELIM, '0, 8'd0);
                    long_pct = 50;
                end
                default: set_cut(t_byte'($urandom_range(255)),
                                 {$urandom, $urandom} & ~64'd1,
                                 t_byte'($urandom_range(255)));
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                send_line(6, long_pct);
            end
            drain_out();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending != 0) begin
            $display("%0d predicted output bytes never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
